>>> rtl/drum_pad_peak_trigger_defines.svh
// Assertion macros shared by the drum pad peak trigger checkers.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef DRUM_PAD_PEAK_TRIGGER_DEFINES_SVH
`define DRUM_PAD_PEAK_TRIGGER_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define DPPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("drum pad peak trigger check failed");

// The consequent must hold at the edge after the antecedent.
`define DPPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("drum pad peak trigger check failed");

`endif

>>> rtl/dppt_pkg.sv
// Shared types and constants for the drum pad peak trigger.
// Used by the divider, the top level and the testbench; depends on nothing else.
`default_nettype none

package dppt_pkg;

    // Field widths and sizes
    localparam int NUM_PADS    = 8;
    localparam int PAD_BITS    = 3;
    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int VEL_BITS    = 7;
    localparam int CFG_BITS    = 20;
    localparam int QUOT_BITS   = 7;
    localparam int NUM_BITS    = SAMPLE_BITS + QUOT_BITS;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;

    // Velocity mapping constants
    localparam logic [VEL_BITS-1:0] VEL_MAX = 7'd127;
    localparam logic [VEL_BITS-1:0] VEL_MIN = 7'd1;

    // Configuration register indexes
    localparam logic CFG_SCAN_WINDOW = 1'b0;
    localparam logic CFG_RETRIGGER   = 1'b1;

    // Input item kinds carried on tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LIMITS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] SCAN_WINDOW_RST = 20'd4000;
    localparam logic [CFG_BITS-1:0] RETRIGGER_RST   = 20'd35000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_WAIT,
        ST_OUT
    } t_state;

    // Request to the shared divider
    typedef struct packed {
        logic                   start;
        logic [NUM_BITS-1:0]    numerator;
        logic [SAMPLE_BITS-1:0] denominator;
    } t_div_req;

endpackage

`default_nettype wire

>>> rtl/drum_pad_peak_trigger.sv
// Drum pad peak trigger: per-pad hit detection on timestamped ADC samples, with peak
// velocity. One transaction is taken at a time. A limit load or a sample that closes no
// hit is evaluated in ST_EVAL and leaves the block ready again; a sample that closes a
// hit goes on through ST_START, ST_WAIT and ST_OUT before the block is ready again: the
// shared divider produces one bit of the 7-bit velocity quotient per cycle while busy,
// and the result may wait in ST_OUT for a free output register.
// A finished result sits in the output register while the next transaction is taken.
// Depends on dppt_pkg and dppt_div.
`default_nettype none

module drum_pad_peak_trigger (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration writes
    input  wire                                  i_cfg_we,
    input  wire                                  i_cfg_idx,
    input  wire  [dppt_pkg::CFG_BITS-1:0]        i_cfg_data,
    // Input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata from bit 0: pad[2:0], sample[14:3], time_us[46:15], low_limit[58:47],
    // high_limit[70:59], zero fill[71]
    input  wire  [dppt_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // tuser: command (0 = sample, 1 = load limits)
    input  wire                                  s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata from bit 0: hit_pad[2:0], velocity[9:3], hit_time_us[41:10], zero fill[47:42]
    output logic [dppt_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import dppt_pkg::*;

    t_state r_state, n_state;

    // Configuration registers
    logic [CFG_BITS-1:0] r_scan_window;
    logic [CFG_BITS-1:0] r_retrigger;

    // Captured input transaction
    logic                   r_cmd;
    logic [PAD_BITS-1:0]    r_pad;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_BITS-1:0]   r_time;
    logic [SAMPLE_BITS-1:0] r_lo_in;
    logic [SAMPLE_BITS-1:0] r_hi_in;

    // Per-pad state
    logic [SAMPLE_BITS-1:0] r_low   [NUM_PADS];
    logic [SAMPLE_BITS-1:0] r_high  [NUM_PADS];
    logic [TIME_BITS-1:0]   r_last  [NUM_PADS];
    logic [TIME_BITS-1:0]   r_start [NUM_PADS];
    logic [SAMPLE_BITS-1:0] r_peak  [NUM_PADS];
    logic [NUM_PADS-1:0]    r_scan;

    // Hit being finished
    logic [PAD_BITS-1:0]    r_hit_pad;
    logic [TIME_BITS-1:0]   r_hit_time;
    logic [SAMPLE_BITS-1:0] r_diff;
    logic [SAMPLE_BITS-1:0] r_range;
    logic                   r_sat;

    // Output register
    logic                   r_out_valid;
    logic [PAD_BITS-1:0]    r_out_pad;
    logic [VEL_BITS-1:0]    r_out_vel;
    logic [TIME_BITS-1:0]   r_out_time;

    // Evaluation signals
    logic [SAMPLE_BITS-1:0] cur_lo, cur_hi, cur_peak, pk_sel, pk_clamp;
    logic [TIME_BITS-1:0]   elapsed, since_hit;
    logic                   win_done, trigger, close, peak_upd, is_scan, win_zero;

    // Sequencer controls
    logic     accept, eval_en, out_load;
    t_div_req div_req;
    logic     div_done;
    logic [QUOT_BITS-1:0] div_quot;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Decision for the captured transaction against its pad's state.
    always_comb begin
        cur_lo    = r_low[r_pad];
        cur_hi    = r_high[r_pad];
        cur_peak  = r_peak[r_pad];
        is_scan   = r_scan[r_pad];
        elapsed   = r_time - r_start[r_pad];
        since_hit = r_time - r_last[r_pad];
        win_zero  = (r_scan_window == '0);
        win_done  = elapsed >= TIME_BITS'(r_scan_window);
        trigger   = !is_scan && (r_sample > cur_lo) && (since_hit > TIME_BITS'(r_retrigger));
        close     = (r_cmd == CMD_SAMPLE) && (is_scan ? win_done : (trigger && win_zero));
        peak_upd  = (r_cmd == CMD_SAMPLE) && is_scan && !win_done && (r_sample > cur_peak);
        pk_sel    = is_scan ? cur_peak : r_sample;
        if (pk_sel < cur_lo) begin
            pk_clamp = cur_lo;
        end else if (pk_sel > cur_hi) begin
            pk_clamp = cur_hi;
        end else begin
            pk_clamp = pk_sel;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_EVAL;
            ST_EVAL:  n_state = close ? ST_START : ST_IDLE;
            ST_START: n_state = ST_WAIT;
            ST_WAIT:  if (div_done) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State-driven controls.
    always_comb begin
        s_axis_tready     = 1'b0;
        eval_en           = 1'b0;
        out_load          = 1'b0;
        div_req.start     = 1'b0;
        div_req.numerator = {r_diff, 7'b0} - {6'b0, r_diff, 1'b0};
        div_req.denominator = r_range;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_EVAL:  eval_en = 1'b1;
            ST_START: div_req.start = 1'b1;
            ST_WAIT:  ;
            ST_OUT:   out_load = !r_out_valid || m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_window <= SCAN_WINDOW_RST;
            r_retrigger   <= RETRIGGER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCAN_WINDOW: r_scan_window <= i_cfg_data;
                CFG_RETRIGGER:   r_retrigger   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Capture of an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= s_axis_tuser;
            r_pad    <= s_axis_tdata[2:0];
            r_sample <= s_axis_tdata[14:3];
            r_time   <= s_axis_tdata[46:15];
            r_lo_in  <= s_axis_tdata[58:47];
            r_hi_in  <= s_axis_tdata[70:59];
        end
    end

    // Per-pad state update during evaluation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                r_low[i]   <= '1;
                r_high[i]  <= '1;
                r_last[i]  <= '0;
                r_start[i] <= '0;
                r_peak[i]  <= '0;
            end
            r_scan <= '0;
        end else if (eval_en) begin
            if (r_cmd == CMD_LIMITS) begin
                r_low[r_pad]  <= r_lo_in;
                r_high[r_pad] <= r_hi_in;
            end else begin
                // A trigger with a zero window closes at once and leaves the pad idle.
                if (trigger) begin
                    r_start[r_pad] <= r_time;
                    r_peak[r_pad]  <= r_sample;
                    r_scan[r_pad]  <= !win_zero;
                end
                if (peak_upd) begin
                    r_peak[r_pad] <= r_sample;
                end
                if (close) begin
                    r_last[r_pad] <= r_time;
                    if (is_scan) begin
                        r_scan[r_pad] <= 1'b0;
                    end
                end
            end
        end
    end

    // Operands of the velocity mapping for a closing hit.
    always_ff @(posedge i_clk) begin
        if (eval_en && close) begin
            r_hit_pad  <= r_pad;
            r_hit_time <= r_time;
            r_diff     <= pk_clamp - cur_lo;
            r_range    <= cur_hi - cur_lo;
            r_sat      <= cur_hi <= cur_lo;
        end
    end

    dppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register: holds a result until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pad  <= r_hit_pad;
            r_out_vel  <= r_sat ? VEL_MAX : (div_quot + VEL_MIN);
            r_out_time <= r_hit_time;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_time, r_out_vel, r_out_pad};

endmodule

`default_nettype wire

>>> rtl/dppt_div.sv
// Restoring divider, one quotient bit per cycle, for the velocity mapping.
// Depends on dppt_pkg for widths and the request struct.
`default_nettype none

module dppt_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  dppt_pkg::t_div_req                  i_req,
    output logic                                o_done,
    output logic [dppt_pkg::QUOT_BITS-1:0]      o_quot
);
    import dppt_pkg::*;

    localparam int DSH_BITS = SAMPLE_BITS + QUOT_BITS - 1;
    localparam int CNT_BITS = $clog2(QUOT_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

    logic [NUM_BITS-1:0]  r_rem, n_rem;
    logic [DSH_BITS-1:0]  r_dsh, n_dsh;
    logic [QUOT_BITS-1:0] r_quot, n_quot;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [NUM_BITS-1:0]  trial;
    logic                 fits;

    // One trial subtraction of the shifted divisor per cycle.
    always_comb begin
        trial  = r_rem - {1'b0, r_dsh};
        fits   = r_rem >= {1'b0, r_dsh};
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_req.start) begin
            n_rem  = i_req.numerator;
            n_dsh  = {i_req.denominator, (QUOT_BITS-1)'(0)};
            n_quot = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = trial;
            end
            n_quot = {r_quot[QUOT_BITS-2:0], fits};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/dppt_checker.sv
// Port-level checks for the drum pad peak trigger, bound to the top level.
// Depends on drum_pad_peak_trigger_defines.svh for the assertion macros.
`default_nettype none
`include "drum_pad_peak_trigger_defines.svh"

module dppt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);

    // A stalled result stays offered.
    `DPPT_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Every velocity lies in 1..127.
    `DPPT_ASSERT_NOW(a_vel_nonzero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[9:3] != 7'd0)

    // The block works on one transaction at a time.
    `DPPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // No result appears in the cycle after an input transaction.
    `DPPT_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind drum_pad_peak_trigger dppt_checker u_dppt_checker (.*);

`default_nettype wire

>>> sim/drum_pad_peak_trigger_tb.sv
// Self-checking testbench for drum_pad_peak_trigger: drives samples and limit loads on the
// input stream, predicts every completed hit and checks each result transaction.
// Depends on dppt_pkg and the drum_pad_peak_trigger RTL.
`timescale 1ns / 100ps

module drum_pad_peak_trigger_tb;

    import dppt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int GAP_PERCENT = 34;

    // One completed hit as it leaves the block.
    typedef struct packed {
        logic [PAD_BITS-1:0]  pad;
        logic [VEL_BITS-1:0]  velocity;
        logic [TIME_BITS-1:0] hit_time;
    } t_hit;

    // Per-pad hit tracker that mirrors the block and holds the hits still to come.
    class hit_scoreboard;
        logic [CFG_BITS-1:0]    window_us;
        logic [CFG_BITS-1:0]    lockout_us;
        logic [SAMPLE_BITS-1:0] low_lim[NUM_PADS];
        logic [SAMPLE_BITS-1:0] high_lim[NUM_PADS];
        logic [SAMPLE_BITS-1:0] peak[NUM_PADS];
        logic [TIME_BITS-1:0]   last_hit[NUM_PADS];
        logic [TIME_BITS-1:0]   scan_start[NUM_PADS];
        bit                     scanning[NUM_PADS];
        t_hit                   pending_hits[$];
        int                     errors;

        function new();
            window_us  = SCAN_WINDOW_RST;
            lockout_us = RETRIGGER_RST;
            errors     = 0;
            for (int i = 0; i < NUM_PADS; i++) begin
                low_lim[i]    = '1;
                high_lim[i]   = '1;
                peak[i]       = '0;
                last_hit[i]   = '0;
                scan_start[i] = '0;
                scanning[i]   = 1'b0;
            end
        endfunction

        function void set_reg(logic idx, logic [CFG_BITS-1:0] value);
            if (idx == CFG_SCAN_WINDOW)
                window_us = value;
            else
                lockout_us = value;
        endfunction

        // Peak clamped to the limits and scaled into 1..127, truncating.
        function logic [VEL_BITS-1:0] map_velocity(logic [SAMPLE_BITS-1:0] lo,
                                                   logic [SAMPLE_BITS-1:0] hi,
                                                   logic [SAMPLE_BITS-1:0] pk);
            int clamped;
            if (hi <= lo)
                return VEL_MAX;
            clamped = int'(pk);
            if (clamped < int'(lo))
                clamped = int'(lo);
            if (clamped > int'(hi))
                clamped = int'(hi);
            return VEL_BITS'(1 + ((clamped - int'(lo)) * 126) / (int'(hi) - int'(lo)));
        endfunction

        function void close_hit(int p, logic [TIME_BITS-1:0] t);
            t_hit h;
            last_hit[p] = t;
            scanning[p] = 1'b0;
            h.pad       = PAD_BITS'(p);
            h.velocity  = map_velocity(low_lim[p], high_lim[p], peak[p]);
            h.hit_time  = t;
            pending_hits.push_back(h);
        endfunction

        // Called for every accepted input transaction.
        function void note_input(logic cmd, logic [S_TDATA_W-1:0] data);
            int                     p;
            logic [SAMPLE_BITS-1:0] smp;
            logic [TIME_BITS-1:0]   t;
            logic [TIME_BITS-1:0]   elapsed;
            p   = int'(data[2:0]);
            smp = data[14:3];
            t   = data[46:15];
            if (cmd == CMD_LIMITS) begin
                low_lim[p]  = data[58:47];
                high_lim[p] = data[70:59];
                return;
            end
            // A scanning pad either closes on this sample or folds it into the peak.
            if (scanning[p]) begin
                elapsed = t - scan_start[p];
                if (elapsed >= TIME_BITS'(window_us))
                    close_hit(p, t);
                else if (smp > peak[p])
                    peak[p] = smp;
                return;
            end
            // An idle pad starts a hit above its low limit once the lockout has passed.
            elapsed = t - last_hit[p];
            if (smp > low_lim[p] && elapsed > TIME_BITS'(lockout_us)) begin
                scanning[p]   = 1'b1;
                scan_start[p] = t;
                peak[p]       = smp;
                if (window_us == '0)
                    close_hit(p, t);
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic [M_TDATA_W-1:0] data);
            t_hit want;
            if (pending_hits.size() == 0) begin
                $error("unexpected result transaction: tdata %h", data);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (data[2:0] != want.pad) begin
                $error("hit_pad mismatch: expected %0d, actual %0d", want.pad, data[2:0]);
                errors++;
            end
            if (data[9:3] != want.velocity) begin
                $error("velocity mismatch: expected %0d, actual %0d", want.velocity,
                       data[9:3]);
                errors++;
            end
            if (data[41:10] != want.hit_time) begin
                $error("hit_time_us mismatch: expected %0d, actual %0d", want.hit_time,
                       data[41:10]);
                errors++;
            end
        endfunction

        function int hits_outstanding();
            return pending_hits.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_idx = 1'b0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata from bit 0: pad, sample, time_us, low_limit, high_limit, zero fill
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
    // tuser: command
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata from bit 0: hit_pad, velocity, hit_time_us, zero fill
    logic [M_TDATA_W-1:0]    m_axis_tdata;

    hit_scoreboard           board;
    bit                      gaps_on = 1'b1;
    logic [TIME_BITS-1:0]    now_us = '0;

    drum_pad_peak_trigger uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, and every result transaction goes to the checker.
    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PERCENT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // Ends the run when no transaction has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offers one input transaction, after an optional random gap, and waits for it to go.
    task automatic send_item(input logic cmd, input logic [PAD_BITS-1:0] pad,
                             input logic [SAMPLE_BITS-1:0] smp,
                             input logic [TIME_BITS-1:0] t,
                             input logic [SAMPLE_BITS-1:0] lo,
                             input logic [SAMPLE_BITS-1:0] hi);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, hi, lo, t, smp, pad};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(cmd, {1'b0, hi, lo, t, smp, pad});
    endtask

    task automatic send_sample(input logic [PAD_BITS-1:0] pad,
                               input logic [SAMPLE_BITS-1:0] smp,
                               input logic [TIME_BITS-1:0] t);
        send_item(CMD_SAMPLE, pad, smp, t, SAMPLE_BITS'($urandom()),
                  SAMPLE_BITS'($urandom()));
    endtask

    task automatic send_limits(input logic [PAD_BITS-1:0] pad,
                               input logic [SAMPLE_BITS-1:0] lo,
                               input logic [SAMPLE_BITS-1:0] hi);
        send_item(CMD_LIMITS, pad, SAMPLE_BITS'($urandom()), $urandom(), lo, hi);
    endtask

    // Holds the input stream off until every expected hit is out and the block is idle.
    task automatic wait_for_hits_drained();
        s_axis_tvalid <= 1'b0;
        while (board.hits_outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both timing registers on consecutive edges; only called while idle.
    task automatic load_timing(input logic [CFG_BITS-1:0] window,
                               input logic [CFG_BITS-1:0] lockout);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCAN_WINDOW;
        i_cfg_data <= window;
        @(posedge i_clk);
        board.set_reg(CFG_SCAN_WINDOW, window);
        i_cfg_idx  <= CFG_RETRIGGER;
        i_cfg_data <= lockout;
        @(posedge i_clk);
        board.set_reg(CFG_RETRIGGER, lockout);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic on a shared clock: mostly samples on random pads, some limit loads,
    // and a few jumps of the time base anywhere in its range.
    task automatic run_random(input int count, input logic [CFG_BITS-1:0] window,
                              input logic [CFG_BITS-1:0] lockout);
        int step_max;
        int pick;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        step_max = ((window > lockout) ? int'(window) : int'(lockout)) / 4 + 3;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                lo = SAMPLE_BITS'($urandom_range(0, 3000));
                hi = SAMPLE_BITS'($urandom_range(0, 4095));
                if ($urandom_range(0, 7) == 0)
                    lo = '0;
                if ($urandom_range(0, 7) == 0)
                    hi = '1;
                send_limits(PAD_BITS'($urandom()), lo, hi);
            end else begin
                if (pick < 10)
                    now_us = $urandom();
                else
                    now_us = now_us + TIME_BITS'($urandom_range(0, step_max));
                send_sample(PAD_BITS'($urandom()), SAMPLE_BITS'($urandom()), now_us);
            end
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset timing of 4000 us window and 35000 us lockout.
        send_limits(3'd0, 12'd100, 12'd3000);
        send_limits(3'd1, 12'd0, 12'd4095);
        send_limits(3'd2, 12'd2000, 12'd2000);     // high equal to low
        send_limits(3'd3, 12'd3000, 12'd1000);     // high below low
        send_limits(3'd4, 12'd0, 12'd1);
        send_limits(3'd5, 12'd4094, 12'd4095);
        send_limits(3'd6, 12'd500, 12'd600);
        send_sample(3'd7, 12'd4095, 32'd40000);    // still at the disabling reset limits
        send_sample(3'd0, 12'd50, 32'd40000);      // below the low limit
        send_sample(3'd0, 12'd4095, 32'd40000);    // starts a hit
        send_sample(3'd0, 12'd200, 32'd41000);
        send_sample(3'd1, 12'd1, 32'd41000);       // just above a zero low limit
        send_limits(3'd0, 12'd0, 12'd100);         // limits change while pad 0 scans
        send_sample(3'd0, 12'd4095, 32'd44000);    // window reached exactly: closes
        send_sample(3'd1, 12'd4095, 32'd44999);    // one microsecond short of the window
        send_sample(3'd1, 12'd0, 32'd45000);
        send_sample(3'd0, 12'd4095, 32'd79000);    // lockout not yet over
        send_sample(3'd0, 12'd4095, 32'd79001);
        send_sample(3'd2, 12'd2001, 32'hFFFF_FFFF);
        send_sample(3'd2, 12'd0, 32'd3998);        // elapsed time wraps through zero
        send_sample(3'd2, 12'd4095, 32'd3999);     // closing sample starts nothing new
        send_sample(3'd0, 12'd0, 32'd83001);
        send_sample(3'd3, 12'd3500, 32'd90000);
        send_sample(3'd3, 12'd3600, 32'd100000);
        now_us = 32'd100000;

        // Random phases over several timing settings, the extremes among them.
        wait_for_hits_drained();
        load_timing(20'd0, 20'd0);                 // zero window closes on the trigger
        run_random(125, 20'd0, 20'd0);
        wait_for_hits_drained();
        load_timing(20'd1000000, 20'd1000000);
        run_random(125, 20'd1000000, 20'd1000000);
        wait_for_hits_drained();
        gaps_on = 1'b0;
        load_timing(20'd37, 20'd120);
        run_random(125, 20'd37, 20'd120);
        wait_for_hits_drained();
        gaps_on = 1'b1;
        load_timing(20'd0, 20'd1000000);
        run_random(125, 20'd0, 20'd1000000);
        wait_for_hits_drained();
        load_timing(20'd1000000, 20'd0);
        run_random(125, 20'd1000000, 20'd0);
        wait_for_hits_drained();
        load_timing(20'd250, 20'd40);
        run_random(125, 20'd250, 20'd40);
        wait_for_hits_drained();

        if (board.errors == 0 && board.hits_outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
